// ===== design/sha1_message_digest_defines.svh =====
// Assertion macros shared by the digest block
`ifndef SHA1_MESSAGE_DIGEST_DEFINES_SVH
`define SHA1_MESSAGE_DIGEST_DEFINES_SVH
// plain implication check with reset gating
`define SHA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// never-true check
`define SHA_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

// ===== design/sha_pkg.sv =====
// Package: types and constants of the SHA-1 digest block
package sha_pkg;
    typedef logic [31:0] t_word;
    localparam t_word H0 = 32'h67452301;
    localparam t_word H1 = 32'hEFCDAB89;
    localparam t_word H2 = 32'h98BADCFE;
    localparam t_word H3 = 32'h10325476;
    localparam t_word H4 = 32'hC3D2E1F0;
    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out;

    // compression control: start request and done pulse
    typedef struct packed {
        logic start;
        logic done;
    } t_cmp_ctl;

    function automatic t_word init_h(input logic [2:0] i);
        t_word r;
        case (i)
            3'd0: r = H0;
            3'd1: r = H1;
            3'd2: r = H2;
            3'd3: r = H3;
            default: r = H4;
        endcase
        return r;
    endfunction

    function automatic t_word rotl(input t_word x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction
endpackage

// ===== design/sha_stream_if.sv =====
// Valid/ready stream interfaces for the digest block
interface sha_in_if import sha_pkg::*; ();
    logic valid;
    logic ready;
    t_in  payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if import sha_pkg::*; ();
    logic valid;
    logic ready;
    t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== design/sha1_message_digest.sv =====
// Top level of the SHA-1 digest block
// SHA-1 message digest over a byte stream.
// Input channel (sha_in_if): one item per handshake; an item carries an
// optional message byte and an optional end-of-message mark.
// Output channel (sha_out_if): after an end mark, five digest words H0..H4
// leave in order, word_index 0..4, last_word set on the fifth.
// Bytes are kept in a 16-word block memory, written one byte lane at a time.
// Each ordinary byte goes to its byte lane; on the 64th byte the round
// engine runs: it loads the 16 block words, then for each of rounds 0..79
// reads the schedule words it needs and computes the round, then raises
// its done flag. Input is held off while a block compresses.
// At the end mark the block is padded byte by byte from the pad position
// (one byte per cycle, possibly across an extra block), compressed,
// and the digest is emitted; a stalled receiver holds each word until taken.
// Reset (synchronous, i_rst_n low) loads the initial chaining values and
// clears fill and length; the block memory needs no clearing since padding
// writes every byte it reads.
module sha1_message_digest import sha_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sha_in_if.sink   i_in,
    sha_out_if.source o_out
);
`include "sha1_message_digest_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMP  = 3'd1;  // block compressing
    localparam logic [2:0] S_PAD  = 3'd2;  // writing pad/zero/length bytes
    localparam logic [2:0] S_OUT  = 3'd3;  // emitting digest

    logic [2:0]  r_state;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic        r_fin;      // end pending: pad after compression
    logic        r_len_blk;  // current pad block carries the length
    logic        r_pad;      // 0x80 byte still to be written
    t_word       r_h [5];
    logic [2:0]  r_idx;

    t_word       buf_mem [16];
    logic        buf_we;
    logic [5:0]  buf_wa;
    logic [7:0]  buf_wd;
    logic [3:0]  blk_addr;
    t_word       r_blk_word;
    logic        cmp_start, cmp_done;
    t_word       sum [5];
    logic [63:0] bits;
    logic        acc;

    // block memory: byte-lane writes, big-endian within a word, registered read
    always_ff @(posedge i_clk) begin
        if (buf_we) buf_mem[buf_wa[5:2]][{~buf_wa[1:0], 3'b000} +: 8] <= buf_wd;
        r_blk_word <= buf_mem[blk_addr];
    end

    sha_compress u_cmp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cmp_start), .i_h(r_h),
        .o_blk_addr(blk_addr), .i_blk_word(r_blk_word),
        .o_done(cmp_done), .o_sum(sum)
    );

    assign bits = {r_count, 3'b000};
    assign i_in.ready = (r_state == S_IDLE);
    assign acc = i_in.valid && i_in.ready;

    always_comb begin
        buf_we = 1'b0;
        buf_wa = r_fill;
        buf_wd = i_in.payload.data_byte;
        cmp_start = 1'b0;
        if (acc && i_in.payload.has_byte) begin
            buf_we = 1'b1;
            cmp_start = (r_fill == 6'd63);
        end
        if (r_state == S_PAD) begin
            buf_we = 1'b1;
            if (r_pad)
                buf_wd = PAD_BYTE;
            else if (r_len_blk && r_fill >= 6'd56)
                buf_wd = bits[{~r_fill[2:0], 3'b111} -: 8];
            else
                buf_wd = 8'h00;
            cmp_start = (r_fill == 6'd63);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill <= '0;
            r_count <= '0;
            r_fin <= 1'b0;
            r_len_blk <= 1'b0;
            r_pad <= 1'b0;
            r_idx <= '0;
            for (int i = 0; i < 5; i++) r_h[i] <= init_h(3'(i));
        end else begin
            case (r_state)
                S_IDLE: if (acc) begin
                    if (i_in.payload.has_byte) begin
                        r_count <= r_count + 61'd1;
                        r_fill <= r_fill + 6'd1;  // wraps to 0 on a full block
                        if (r_fill == 6'd63) begin
                            r_state <= S_CMP;
                            r_fin <= i_in.payload.end_of_message;
                        end
                    end
                    if (i_in.payload.end_of_message) begin
                        // pad byte goes in at the next free position
                        r_pad <= 1'b1;
                        if (!(i_in.payload.has_byte && r_fill == 6'd63))
                            r_state <= S_PAD;
                    end
                end
                S_PAD: begin
                    r_fill <= r_fill + 6'd1;
                    if (r_pad) begin
                        r_pad <= 1'b0;
                        r_len_blk <= (r_fill < 6'd56);
                    end
                    if (r_fill == 6'd63) begin
                        r_state <= S_CMP;
                        r_fin <= r_pad || !r_len_blk;
                    end
                end
                S_CMP: if (cmp_done) begin
                    for (int i = 0; i < 5; i++) r_h[i] <= sum[i];
                    if (r_fin) begin
                        r_fin <= 1'b0; r_len_blk <= 1'b1; r_state <= S_PAD;
                    end else if (r_len_blk) begin
                        r_state <= S_OUT; r_idx <= '0;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: if (o_out.ready) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd4) begin
                        r_state <= S_IDLE;
                        r_count <= '0; r_fill <= '0; r_len_blk <= 1'b0;
                        for (int i = 0; i < 5; i++) r_h[i] <= init_h(3'(i));
                    end
                end
            endcase
        end
    end

    assign o_out.valid = (r_state == S_OUT);
    assign o_out.payload.digest_word = r_h[r_idx];
    assign o_out.payload.word_index = r_idx;
    assign o_out.payload.last_word = (r_idx == 3'd4);

    `SHA_NEVER(a_no_in_busy, i_clk, i_rst_n, acc && r_state != S_IDLE, "input taken while busy")
    `SHA_ASSERT(a_idx, i_clk, i_rst_n, o_out.valid |-> r_idx <= 3'd4, "bad word index")
    `SHA_ASSERT(a_done_cmp, i_clk, i_rst_n, cmp_done |-> r_state == S_CMP, "done outside compress")
endmodule

// ===== design/sha_compress.sv =====
// SHA-1 round engine: 80 rounds, schedule window in a 16-word memory
module sha_compress import sha_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_word       i_h [5],
    // block word fetch: address out, data back on the next cycle
    output logic [3:0]  o_blk_addr,
    input  t_word       i_blk_word,
    output logic        o_done,
    output t_word       o_sum [5]
);
    // phases: LOAD 16 words, then per round READ (1 read for rounds 0..15, 4 reads after) and ROUND
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOAD = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_RND  = 2'd3;

    logic [1:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;     // load word / read step
    logic [6:0] r_t, n_t;         // round number
    t_word r_a, r_b, r_c, r_d, r_e;
    t_word r_x;                   // schedule xor accumulator
    t_word w_mem [16];
    t_word r_rd;
    logic [3:0] rd_addr;
    logic       we;
    logic [3:0] wa;
    t_word      wd;
    logic       r_done;
    t_word f, k, w, tmp;

    // memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (we) w_mem[wa] <= wd;
        r_rd <= w_mem[rd_addr];
    end

    // read schedule: t+13, t+8, t+2, t over steps 0..3; step 4 consumes last; rounds 0..15 read word t
    always_comb begin
        case (r_cnt[1:0])
            2'd0: rd_addr = r_t[3:0] + 4'd13;
            2'd1: rd_addr = r_t[3:0] + 4'd8;
            2'd2: rd_addr = r_t[3:0] + 4'd2;
            default: rd_addr = r_t[3:0];
        endcase
        if (r_t < 7'd16) rd_addr = r_t[3:0];
    end

    always_comb begin
        if (r_t < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d); k = K0;
        end else if (r_t < 7'd40) begin
            f = r_b ^ r_c ^ r_d; k = K1;
        end else if (r_t < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d; k = K3;
        end
        w = (r_t < 7'd16) ? r_rd : rotl(r_x ^ r_rd, 1);
        tmp = rotl(r_a, 5) + f + r_e + w + k;
    end

    assign o_blk_addr = r_cnt[3:0];

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_t = r_t;
        we = 1'b0;
        wa = r_t[3:0];
        wd = w;
        case (r_state)
            S_IDLE: if (i_start) begin
                n_state = S_LOAD; n_cnt = '0;
            end
            S_LOAD: begin
                // word of previous address arrives now
                n_cnt = r_cnt + 5'd1;
                if (r_cnt != 5'd0) begin
                    we = 1'b1; wa = 4'(r_cnt - 5'd1); wd = i_blk_word;
                end
                if (r_cnt == 5'd16) begin
                    n_state = S_RD; n_cnt = '0; n_t = '0;
                end
            end
            S_RD: begin
                n_cnt = r_cnt + 5'd1;
                if (r_t < 7'd16 || r_cnt == 5'd3) n_state = S_RND;
            end
            default: begin
                we = (r_t >= 7'd16);
                n_t = r_t + 7'd1;
                n_cnt = '0;
                n_state = (r_t == 7'd79) ? S_IDLE : S_RD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_t <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_t <= n_t;
            r_done <= (r_state == S_RND) && (r_t == 7'd79);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_a <= i_h[0]; r_b <= i_h[1]; r_c <= i_h[2]; r_d <= i_h[3]; r_e <= i_h[4];
        end
        if (r_state == S_RD) begin
            if (r_cnt == 5'd1) r_x <= r_rd;
            else if (r_cnt != 5'd0) r_x <= r_x ^ r_rd;
        end
        if (r_state == S_RND) begin
            r_e <= r_d; r_d <= r_c; r_c <= rotl(r_b, 30); r_b <= r_a; r_a <= tmp;
        end
    end

    assign o_done = r_done;
    assign o_sum[0] = i_h[0] + r_a;
    assign o_sum[1] = i_h[1] + r_b;
    assign o_sum[2] = i_h[2] + r_c;
    assign o_sum[3] = i_h[3] + r_d;
    assign o_sum[4] = i_h[4] + r_e;
endmodule
